// ----- sv/dpi_pkg.sv -----
// shared types, codes and an arithmetic helper of the damped particle integrator
package dpi_pkg;

    localparam int CompW = 32;
    localparam int DampW = 17;
    localparam int StepW = 16;
    localparam int Lanes = 3;
    localparam int RootN = 16;

    typedef enum logic [2:0] {
        REQ_TICK  = 3'd0,
        REQ_FORCE = 3'd1,
        REQ_CLEAR = 3'd2,
        REQ_LVEL  = 3'd3,
        REQ_LPOS  = 3'd4
    } req_t;

    typedef enum logic [2:0] {
        CFG_IMASS = 3'd0,
        CFG_DAMP  = 3'd1,
        CFG_BAX   = 3'd2,
        CFG_BAY   = 3'd3,
        CFG_BAZ   = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_POW,
        ST_LANE,
        ST_OUT
    } state_t;

    // lane control from the sequencer
    typedef struct packed {
        logic       start;
        logic [2:0] phase;
    } lane_ctl_t;

    // saturate a 66-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647) return 32'sh7fffffff;
        if (x < -66'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

endpackage

// ----- sv/dpi_sqrt.sv -----
// iterative integer square root, one result bit per cycle
module dpi_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    import dpi_pkg::*;

    logic [63:0] rad_reg, rad_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] res_reg, res_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [33:0] part;
    logic [33:0] trial;
    logic [33:0] diff;

    // restoring form: bring down two radicand bits, try subtracting 4*res + 1
    always_comb begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done      = 1'b0;
        part      = {rem_reg, rad_reg[63:62]};
        trial     = {res_reg, 2'b01};
        diff      = part - trial;
        if (start) begin
            rad_next  = radicand;
            rem_next  = 32'd0;
            res_next  = 32'd0;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next = {rad_reg[61:0], 2'b00};
            if (part >= trial) begin
                rem_next = diff[31:0];
                res_next = {res_reg[30:0], 1'b1};
            end else begin
                rem_next = part[31:0];
                res_next = {res_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rad_reg <= rad_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign root = res_next;
endmodule

// ----- sv/dpi_lane.sv -----
// one axis of the integrator: position, velocity and force of a single component
module dpi_lane (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  dpi_pkg::lane_ctl_t      ctl,
    input  logic [2:0]              req,
    input  logic [15:0]             t,
    input  logic signed [31:0]      vec,
    input  logic [31:0]             inv_mass,
    input  logic signed [31:0]      base,
    input  logic [32:0]             pw,
    output logic signed [31:0]      pos,
    output logic signed [31:0]      vel
);
    import dpi_pkg::*;

    logic signed [31:0] pos_reg, vel_reg, frc_reg, acc_reg, v1_reg;
    logic signed [31:0] pos_next, vel_next, frc_next, acc_next, v1_next;
    logic signed [65:0] prod;
    logic signed [65:0] rnd;

    // one multiply per phase, rounded and saturated
    always_comb begin
        pos_next = pos_reg;
        vel_next = vel_reg;
        frc_next = frc_reg;
        acc_next = acc_reg;
        v1_next  = v1_reg;
        prod     = 66'sd0;
        rnd      = 66'sd0;
        if (ctl.start) begin
            unique case (req)
                REQ_FORCE: frc_next = sat32(66'(frc_reg) + 66'(vec));
                REQ_CLEAR: frc_next = 32'sd0;
                REQ_LVEL:  vel_next = vec;
                REQ_LPOS:  pos_next = vec;
                default:   ;
            endcase
        end else begin
            unique case (ctl.phase)
                3'd1: begin
                    prod = 66'(frc_reg) * $signed({34'd0, inv_mass});
                    rnd  = (prod + 66'sd32768) >>> 16;
                    acc_next = sat32(66'(base) + 66'(sat32(rnd)));
                end
                3'd2: begin
                    prod = 66'(vel_reg) * $signed({50'd0, t});
                    rnd  = (prod + 66'sd16384) >>> 15;
                    pos_next = sat32(66'(pos_reg) + rnd);
                end
                3'd3: begin
                    prod = 66'(acc_reg) * $signed({50'd0, t});
                    rnd  = (prod + 66'sd16384) >>> 15;
                    v1_next = sat32(66'(vel_reg) + rnd);
                end
                3'd4: begin
                    prod = 66'(v1_reg) * $signed({33'd0, pw});
                    rnd  = (prod + 66'sh80000000) >>> 32;
                    vel_next = sat32(rnd);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 32'sd0;
            vel_reg <= 32'sd0;
            frc_reg <= 32'sd0;
        end else begin
            pos_reg <= pos_next;
            vel_reg <= vel_next;
            frc_reg <= frc_next;
        end
        acc_reg <= acc_next;
        v1_reg  <= v1_next;
    end

    assign pos = pos_reg;
    assign vel = vel_reg;
endmodule

// ----- sv/damped_particle_integrator.sv -----
// top level: sequencer, damping power unit, three axis lanes and result register
//
// channel  | dir | contents
// s_axis   | in  | request: req_type, time_step, vec_x/y/z
// m_axis   | out | pos_x/y/z, vel_x/y/z
// cfg      | in  | register write, no read-back
//
// a non-tick request or a zero time_step tick goes from accept to the output state;
// a tick with damping zero or at least one runs the four lane phases and then the
// output state; any other tick first runs the shared square-root unit once per
// damping root (fifteen roots) and one power step per time_step bit. the result
// sits in an output register; the next request is taken in the cycle after it is
// delivered. reset clears the sequencer state, output flag, configuration and lane state.
module damped_particle_integrator (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // time_step(16), vec_x, vec_y, vec_z
    input  logic [2:0]   s_tuser,   // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import dpi_pkg::*;
    // s_tdata bits: time_step [15:0], vec_x [47:16], vec_y [79:48], vec_z [111:80]

    logic [31:0]        imass_reg;
    logic [16:0]        damp_reg;
    logic signed [31:0] base_reg [Lanes];
    state_t             st_reg, st_next;
    logic [15:0]        t_reg;
    logic [31:0]        roots_reg [RootN];
    logic [3:0]         k_reg, k_next;
    logic [32:0]        p_reg, p_next;
    logic [2:0]         ph_reg, ph_next;
    logic               sq_start, sq_done;
    logic [31:0]        sq_root;
    logic [64:0]        pmul;
    logic [191:0]       out_reg;
    logic               ov_reg;
    lane_ctl_t          ctl;
    logic signed [31:0] lpos [Lanes];
    logic signed [31:0] lvel [Lanes];
    logic               accept;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (st_reg == ST_IDLE) && !ov_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            imass_reg <= 32'd0;
            damp_reg  <= 17'd0;
            for (int i = 0; i < Lanes; i++) base_reg[i] <= 32'sd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_IMASS: imass_reg   <= cfg_data;
                CFG_DAMP:  damp_reg    <= cfg_data[16:0];
                CFG_BAX:   base_reg[0] <= cfg_data;
                CFG_BAY:   base_reg[1] <= cfg_data;
                CFG_BAZ:   base_reg[2] <= cfg_data;
                default:   ;
            endcase
        end
    end

    dpi_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start),
        .radicand({roots_reg[k_reg - 4'd1], 32'd0}), .done(sq_done), .root(sq_root)
    );

    assign pmul = 65'(p_reg) * 65'(roots_reg[k_reg]);

    // sequencer
    always_comb begin
        st_next  = st_reg;
        k_next   = k_reg;
        p_next   = p_reg;
        ph_next  = 3'd0;
        sq_start = 1'b0;
        ctl.start = 1'b0;
        ctl.phase = 3'd0;
        unique case (st_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == REQ_TICK && s_tdata[15:0] != 16'd0) begin
                        k_next = 4'd1;
                        if (damp_reg >= 17'd65536) begin
                            p_next  = 33'h100000000;
                            st_next = ST_LANE;
                            ph_next = 3'd1;
                        end else if (damp_reg == 17'd0) begin
                            p_next  = 33'd0;
                            st_next = ST_LANE;
                            ph_next = 3'd1;
                        end else begin
                            st_next = ST_ROOT;
                            sq_start = 1'b0;
                        end
                    end else begin
                        st_next = ST_OUT;
                    end
                end
            end
            ST_ROOT: begin
                sq_start = (ph_reg == 3'd0);
                ph_next  = 3'd1;
                if (sq_done) begin
                    ph_next = 3'd0;
                    if (k_reg == 4'd15) begin
                        k_next  = 4'd0;
                        p_next  = 33'h100000000;
                        st_next = ST_POW;
                    end else begin
                        k_next = k_reg + 4'd1;
                    end
                end
            end
            ST_POW: begin
                if (t_reg[4'd15 - k_reg]) p_next = {1'b0, pmul[63:32]};
                k_next = k_reg + 4'd1;
                if (k_reg == 4'd15) begin
                    st_next = ST_LANE;
                    ph_next = 3'd1;
                end
            end
            ST_LANE: begin
                ctl.phase = ph_reg;
                ph_next   = ph_reg + 3'd1;
                if (ph_reg == 3'd4) st_next = ST_OUT;
            end
            ST_OUT: begin
                st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
        if (accept) ctl.start = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            ph_reg <= 3'd0;
            ov_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            ph_reg <= ph_next;
            if (st_reg == ST_OUT) ov_reg <= 1'b1;
            else if (m_tready) ov_reg <= 1'b0;
        end
        k_reg <= k_next;
        p_reg <= p_next;
        if (accept) begin
            t_reg        <= s_tdata[15:0];
            roots_reg[0] <= {damp_reg[15:0], 16'd0};
        end
        if (st_reg == ST_ROOT && sq_done) roots_reg[k_reg] <= sq_root;
        if (st_reg == ST_OUT) begin
            for (int i = 0; i < Lanes; i++) begin
                out_reg[32*i +: 32]     <= lpos[i];
                out_reg[96 + 32*i +: 32] <= lvel[i];
            end
        end
    end

    // lanes work on the request directly at accept
    for (genvar g = 0; g < Lanes; g++) begin : g_lane
        dpi_lane u_lane (
            .aclk(aclk), .aresetn(aresetn), .ctl(ctl), .req(s_tuser),
            .t(t_reg), .vec(s_tdata[16 + 32*g +: 32]),
            .inv_mass(imass_reg), .base(base_reg[g]), .pw(p_reg),
            .pos(lpos[g]), .vel(lvel[g])
        );
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = out_reg;
endmodule

// ----- tb/sv/testbench.sv -----
// testbench for the damped particle integrator: self-checking stream test with a scoreboard
`timescale 1ns / 100ps

module testbench;
    import dpi_pkg::*;

    localparam int WatchdogLimit = 40000;
    localparam int RandomItems = 1750;
    localparam int PhaseCount = 7;

    // scoreboard: own copy of particle state and registers, expected results in order
    class particle_scoreboard;
        logic signed [31:0] pos_q[3];
        logic signed [31:0] vel_q[3];
        logic signed [31:0] force_q[3];
        logic [31:0] imass;
        logic [16:0] damp;
        logic signed [31:0] accel[3];
        logic [191:0] expected_q[$];
        int mismatches;

        function new();
            for (int i = 0; i < 3; i++) begin
                pos_q[i] = 0;
                vel_q[i] = 0;
                force_q[i] = 0;
                accel[i] = 0;
            end
            imass = 0;
            damp = 0;
            mismatches = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [31:0] value);
            case (idx)
                CFG_IMASS: imass = value;
                CFG_DAMP:  damp = value[16:0];
                CFG_BAX:   accel[0] = value;
                CFG_BAY:   accel[1] = value;
                CFG_BAZ:   accel[2] = value;
                default: ;
            endcase
        endfunction

        function logic signed [31:0] clamp(longint x);
            if (x > 64'sd2147483647) return 32'sh7fffffff;
            if (x < -64'sd2147483648) return 32'sh80000000;
            return x[31:0];
        endfunction

        // round half up, then drop s fraction bits
        function longint round_drop(longint x, int s);
            return (x + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (n >= res + bitv) begin
                    n = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        // damping raised to t seconds, unsigned Q1.32
        function longint unsigned damp_power(logic [15:0] t);
            longint unsigned roots[16];
            longint unsigned p;
            p = 64'd1 << 32;
            if (damp >= 17'd65536) return p;
            if (damp == 0) return 0;
            roots[0] = longint'(damp) << 16;
            for (int k = 1; k < 16; k++) roots[k] = int_sqrt(roots[k - 1] << 32);
            for (int k = 0; k < 16; k++)
                if (t[15 - k]) p = (p * roots[k]) >> 32;
            return p;
        endfunction

        function void integrate(logic [15:0] t);
            longint unsigned p;
            longint dp, fm, acc, dv, v1;
            if (t == 0) return;
            p = damp_power(t);
            for (int i = 0; i < 3; i++) begin
                dp = round_drop(longint'(vel_q[i]) * longint'(t), 15);
                fm = clamp(round_drop(longint'(force_q[i]) * longint'({32'd0, imass}), 16));
                acc = clamp(longint'(accel[i]) + fm);
                dv = round_drop(acc * longint'(t), 15);
                v1 = clamp(longint'(vel_q[i]) + dv);
                pos_q[i] = clamp(longint'(pos_q[i]) + dp);
                vel_q[i] = clamp(round_drop(v1 * longint'(p), 32));
            end
        endfunction

        function void note_request(logic [2:0] kind, logic [111:0] data);
            logic signed [31:0] v[3];
            logic [191:0] r;
            for (int i = 0; i < 3; i++) v[i] = data[16 + 32 * i +: 32];
            case (kind)
                REQ_TICK:  integrate(data[15:0]);
                REQ_FORCE: for (int i = 0; i < 3; i++)
                    force_q[i] = clamp(longint'(force_q[i]) + longint'(v[i]));
                REQ_CLEAR: for (int i = 0; i < 3; i++) force_q[i] = 0;
                REQ_LVEL:  for (int i = 0; i < 3; i++) vel_q[i] = v[i];
                REQ_LPOS:  for (int i = 0; i < 3; i++) pos_q[i] = v[i];
                default: ;
            endcase
            for (int i = 0; i < 3; i++) begin
                r[32 * i +: 32] = pos_q[i];
                r[96 + 32 * i +: 32] = vel_q[i];
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [191:0] got);
            logic [191:0] want;
            string names[6];
            names = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z"};
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = expected_q.pop_front();
            for (int f = 0; f < 6; f++) begin
                if (got[32 * f +: 32] !== want[32 * f +: 32]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%s mismatch: expected %h, actual %h", names[f],
                                 want[32 * f +: 32], got[32 * f +: 32]);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;   // time_step(16), vec_x, vec_y, vec_z
    logic [2:0]   s_tuser;   // req_type
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    particle_scoreboard sb;
    int send_idle;
    int recv_idle;
    int quiet_cycles;

    damped_particle_integrator u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // clock
    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // monitor both channels and the watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WatchdogLimit) begin
                $display("watchdog expired");
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // register write, only while idle
    task automatic write_cfg(cfg_idx_t idx, logic [31:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(posedge aclk);
        sb.write_reg(idx, value);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // hold requests until every expected result has come back
    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic send_req(logic [2:0] kind, logic [15:0] dt,
                            logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
        if ($urandom_range(99) < send_idle) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tuser = kind;
        s_tdata = {vz, vy, vx, dt};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2, 3: return $urandom;
            default: return $urandom_range(0, 32'h003fffff) - 32'h00200000;
        endcase
    endfunction

    function automatic logic [15:0] rand_step();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hffff;
            2, 3: return 16'($urandom);
            default: return 16'($urandom_range(1, 16'h0400));
        endcase
    endfunction

    task automatic set_phase_cfg(int phase);
        logic [31:0] im;
        logic [31:0] dm;
        if (phase == PhaseCount - 1) begin
            im = 32'hffffffff;
            dm = 32'h0001ffff;
        end else begin
            im = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 32'h00040000);
            case ($urandom_range(5))
                0: dm = 0;
                1: dm = 32'd65536;
                2: dm = $urandom_range(0, 32'h1ffff);
                default: dm = $urandom_range(40000, 65535);
            endcase
        end
        write_cfg(CFG_IMASS, im);
        write_cfg(CFG_DAMP, dm);
        write_cfg(CFG_BAX, (phase == PhaseCount - 1) ? 32'h7fffffff : rand_comp());
        write_cfg(CFG_BAY, (phase == PhaseCount - 1) ? 32'h80000000 : rand_comp());
        write_cfg(CFG_BAZ, rand_comp());
    endtask

    initial begin
        logic [2:0] kind;
        int per_phase;
        sb = new();
        send_idle = 19;
        recv_idle = 46;
        quiet_cycles = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        repeat (2) @(negedge aclk);

        // directed: zero registers, so damping zero zeroes velocity
        send_req(REQ_TICK, 16'hffff, 0, 0, 0);
        send_req(REQ_LVEL, 0, 32'h7fffffff, 32'h80000000, 32'h00010000);
        send_req(REQ_TICK, 16'h0000, 0, 0, 0);
        send_req(REQ_TICK, 16'h0001, 0, 0, 0);
        send_req(REQ_LPOS, 16'hffff, 32'h7fffffff, 32'h80000000, 32'hffffffff);
        send_req(3'd5, 16'h1234, 32'h1, 32'h2, 32'h3);
        send_req(3'd7, 16'hffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        drain();

        // directed: unit damping, unit inverse mass, force saturation
        write_cfg(CFG_IMASS, 32'h00010000);
        write_cfg(CFG_DAMP, 32'd65536);
        write_cfg(CFG_BAX, 32'h7fffffff);
        write_cfg(CFG_BAY, 32'h80000000);
        write_cfg(CFG_BAZ, 32'h00000000);
        send_req(REQ_FORCE, 0, 32'h7fffffff, 32'h80000000, 32'h00010000);
        send_req(REQ_FORCE, 0, 32'h7fffffff, 32'h80000000, 32'hffff0000);
        send_req(REQ_LVEL, 0, 32'h7fff0000, 32'h80010000, 32'h00000000);
        send_req(REQ_TICK, 16'hffff, 0, 0, 0);
        send_req(REQ_TICK, 16'h8000, 0, 0, 0);
        send_req(REQ_CLEAR, 16'hffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_req(REQ_TICK, 16'h0001, 0, 0, 0);
        send_req(3'd6, 0, 0, 0, 0);
        drain();

        // random phases with changing registers and idling modes
        per_phase = RandomItems / PhaseCount;
        for (int ph = 0; ph < PhaseCount; ph++) begin
            set_phase_cfg(ph);
            if (ph < 2) begin
                send_idle = 19;
                recv_idle = 46;
            end else if (ph < 4) begin
                send_idle = 46;
                recv_idle = 19;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            for (int n = 0; n < per_phase; n++) begin
                case ($urandom_range(19))
                    0, 1, 2, 3, 4, 5, 6, 7: kind = REQ_TICK;
                    8, 9, 10, 11: kind = REQ_FORCE;
                    12: kind = REQ_CLEAR;
                    13, 14, 15: kind = REQ_LVEL;
                    16, 17: kind = REQ_LPOS;
                    default: kind = 3'($urandom_range(5, 7));
                endcase
                send_req(kind, rand_step(), rand_comp(), rand_comp(), rand_comp());
            end
            drain();
        end

        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
